FILE: hdl/voltage_heartbeat_pulse_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Heartbeat scheduler assertion macros
// Clocked assertion wrappers shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_HEARTBEAT_PULSE_SCHEDULER_ASSERT_SVH
`define VOLTAGE_HEARTBEAT_PULSE_SCHEDULER_ASSERT_SVH

// check a property at every clock edge outside reset
`define VHPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define VHPS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/vhps_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat scheduler package
// Field widths, register indexes, reset values and ADC channel codes.
// ----------------------------------------------------------------------------
package vhps_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 16;
    localparam int GAIN_W     = 4;
    localparam int OFFSET_W   = 12;
    localparam int GAPS_W     = 8;
    localparam int CHANNEL_W  = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAP_STEP       = 2'd0,
        REG_PULSE_GAIN     = 2'd1,
        REG_PULSE_OFFSET   = 2'd2,
        REG_GAPS_PER_FRAME = 2'd3
    } cfg_reg_t;

    localparam logic [TIME_W-1:0]    GAP_STEP_RST       = 16'd60000;
    localparam logic [GAIN_W-1:0]    PULSE_GAIN_RST     = 4'd3;
    localparam logic [OFFSET_W-1:0]  PULSE_OFFSET_RST   = 12'd200;
    localparam logic [GAPS_W-1:0]    GAPS_PER_FRAME_RST = 8'd5;

    localparam logic [CHANNEL_W-1:0] ADC_CH_ONE   = 2'd1;
    localparam logic [CHANNEL_W-1:0] ADC_CH_TWO   = 2'd2;
    localparam logic [CHANNEL_W-1:0] ADC_CH_THREE = 2'd3;

endpackage

FILE: hdl/vhps_in_if.sv
// ----------------------------------------------------------------------------
// Heartbeat scheduler sample channel
// Valid/ready channel carrying one ADC sample per beat.
// ----------------------------------------------------------------------------
interface vhps_in_if;
    import vhps_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);

endinterface

FILE: hdl/vhps_out_if.sv
// ----------------------------------------------------------------------------
// Heartbeat scheduler result channel
// Valid/ready channel carrying compare time, pin levels and ADC control.
// ----------------------------------------------------------------------------
interface vhps_out_if;
    import vhps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_W-1:0]    next_compare;
    logic                 status_one;
    logic                 status_two;
    logic [CHANNEL_W-1:0] adc_channel;
    logic                 adc_enable;

    modport source (
        output valid, output next_compare, output status_one, output status_two,
        output adc_channel, output adc_enable, input ready
    );
    modport sink (
        input valid, input next_compare, input status_one, input status_two,
        input adc_channel, input adc_enable, output ready
    );

endinterface

FILE: hdl/voltage_heartbeat_pulse_scheduler.sv
// ----------------------------------------------------------------------------
// Voltage heartbeat pulse scheduler
// Usage:
//   sample : one beat per timer-compare event, carrying the latest ADC sample.
//   result : one beat per sample: next compare time, the two status pin levels,
//            the ADC channel to convert next and the ADC enable.
//   cfg_we/cfg_index/cfg_data : register writes, taken at any edge with
//            cfg_we high; write only while no beat is in flight.
// The sample is held in an input register, then the phase update and the
// 4x10 bit multiply-add for edge spacing run combinationally into the
// result register.
// Throughput is one beat per cycle while the receiver is ready; the phase
// state is updated as each sample leaves the input register: no gap between beats.
// Reset puts the block in the gap phase with five gaps to go, both times at
// zero, ADC on channel 1 and disabled, and registers at their defaults.
// When the receiver stalls, the result is held and the input register still
// takes one more beat; sample.ready falls only when both stages are full.
// ----------------------------------------------------------------------------
module voltage_heartbeat_pulse_scheduler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vhps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vhps_pkg::CFG_DATA_W-1:0]      cfg_data,
    vhps_in_if.sink                              sample,
    vhps_out_if.source                           result
);
    import vhps_pkg::*;

    typedef enum logic [1:0] {
        PH_GAP  = 2'd0,
        PH_ON1  = 2'd1,
        PH_OFF1 = 2'd2,
        PH_ON2  = 2'd3
    } phase_t;

    logic [TIME_W-1:0]    gap_step_reg;
    logic [GAIN_W-1:0]    pulse_gain_reg;
    logic [OFFSET_W-1:0]  pulse_offset_reg;
    logic [GAPS_W-1:0]    gaps_per_frame_reg;

    phase_t               phase_reg, phase_next;
    logic [GAPS_W-1:0]    gaps_left_reg, gaps_left_next;
    logic [TIME_W-1:0]    heartbeat_reg, heartbeat_next;
    logic [TIME_W-1:0]    edge_reg, edge_next;
    logic                 chan_sel_reg, chan_sel_next;
    logic [CHANNEL_W-1:0] adc_chan_reg, adc_chan_next;
    logic                 adc_en_reg, adc_en_next;

    logic                 in_valid_reg;
    logic [SAMPLE_W-1:0]  in_sample_reg;

    logic                 out_valid_reg;
    logic [TIME_W-1:0]    cmp_reg, cmp_next;
    logic                 s1_reg, s1_next;
    logic                 s2_reg, s2_next;

    logic                 advance;
    logic                 pulse_on;
    logic [SAMPLE_W+GAIN_W-1:0] scaled;
    logic [TIME_W-1:0]    spacing;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    assign scaled  = (SAMPLE_W+GAIN_W)'(pulse_gain_reg) * (SAMPLE_W+GAIN_W)'(in_sample_reg);
    assign spacing = TIME_W'(scaled) + TIME_W'(pulse_offset_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        gaps_left_next = gaps_left_reg;
        heartbeat_next = heartbeat_reg;
        edge_next      = edge_reg;
        chan_sel_next  = chan_sel_reg;
        adc_chan_next  = adc_chan_reg;
        adc_en_next    = adc_en_reg;
        cmp_next       = edge_reg;
        pulse_on       = 1'b0;
        unique case (phase_reg)
            PH_GAP:
            begin
                heartbeat_next = heartbeat_reg + gap_step_reg;
                cmp_next       = heartbeat_next;
                gaps_left_next = gaps_left_reg - GAPS_W'(1);
                if (gaps_left_next == '0)
                begin
                    chan_sel_next = !chan_sel_reg;
                    adc_chan_next = ADC_CH_ONE;
                    adc_en_next   = 1'b1;
                    phase_next    = PH_ON1;
                end
            end
            PH_ON1:
            begin
                pulse_on      = 1'b1;
                edge_next     = heartbeat_reg + spacing;
                cmp_next      = edge_next;
                adc_chan_next = ADC_CH_TWO;
                adc_en_next   = 1'b1;
                phase_next    = PH_OFF1;
            end
            PH_OFF1:
            begin
                edge_next     = edge_reg + spacing;
                cmp_next      = edge_next;
                adc_chan_next = ADC_CH_THREE;
                adc_en_next   = 1'b1;
                phase_next    = PH_ON2;
            end
            PH_ON2:
            begin
                pulse_on       = 1'b1;
                edge_next      = edge_reg + spacing;
                cmp_next       = edge_next;
                adc_en_next    = 1'b0;
                gaps_left_next = gaps_per_frame_reg;
                phase_next     = PH_GAP;
            end
            default:
            begin
                phase_next = PH_GAP;
            end
        endcase
        s1_next = pulse_on && chan_sel_next;
        s2_next = pulse_on && !chan_sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_step_reg       <= GAP_STEP_RST;
            pulse_gain_reg     <= PULSE_GAIN_RST;
            pulse_offset_reg   <= PULSE_OFFSET_RST;
            gaps_per_frame_reg <= GAPS_PER_FRAME_RST;
            phase_reg          <= PH_GAP;
            gaps_left_reg      <= GAPS_PER_FRAME_RST;
            heartbeat_reg      <= '0;
            edge_reg           <= '0;
            chan_sel_reg       <= 1'b0;
            adc_chan_reg       <= ADC_CH_ONE;
            adc_en_reg         <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GAP_STEP:       gap_step_reg       <= cfg_data[TIME_W-1:0];
                    REG_PULSE_GAIN:     pulse_gain_reg     <= cfg_data[GAIN_W-1:0];
                    REG_PULSE_OFFSET:   pulse_offset_reg   <= cfg_data[OFFSET_W-1:0];
                    REG_GAPS_PER_FRAME: gaps_per_frame_reg <= cfg_data[GAPS_W-1:0];
                    default:            gap_step_reg       <= gap_step_reg;
                endcase
            end

            if (sample.valid && sample.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg     <= phase_next;
                gaps_left_reg <= gaps_left_next;
                heartbeat_reg <= heartbeat_next;
                edge_reg      <= edge_next;
                chan_sel_reg  <= chan_sel_next;
                adc_chan_reg  <= adc_chan_next;
                adc_en_reg    <= adc_en_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_sample_reg <= sample.adc_sample;
        end
        if (advance)
        begin
            cmp_reg <= cmp_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.next_compare = cmp_reg;
    assign result.status_one   = s1_reg;
    assign result.status_two   = s2_reg;
    assign result.adc_channel  = adc_chan_reg;
    assign result.adc_enable   = adc_en_reg;

`include "voltage_heartbeat_pulse_scheduler_assert.svh"

    `VHPS_ASSERT(a_adc_en_tracks_phase,
        adc_en_reg == (phase_reg != PH_GAP),
        "ADC enable out of step with phase")
    `VHPS_ASSERT(a_gaps_done_in_pulse,
        (phase_reg == PH_GAP) || (gaps_left_reg == '0),
        "gap count not exhausted in pulse phase")
    `VHPS_ASSERT(a_pin_only_after_on,
        !(out_valid_reg && (s1_reg || s2_reg)) || (phase_reg == PH_OFF1) || (phase_reg == PH_GAP),
        "status pin high outside a pulse-on result")
    `VHPS_ASSERT_NEXT(a_advance_fills_result, advance, out_valid_reg, "advanced beat lost")

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Heartbeat pulse scheduler testbench
// Streams ADC samples through the scheduler under random idling on both
// channels and checks every result beat against a cycle-free model of the
// gap / pulse-on / pulse-off / pulse-on sequence, re-programming the
// registers between bursts of traffic.
// ----------------------------------------------------------------------------
module testbench;
    import vhps_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [1:0] {
        SLOT_GAP       = 2'd0,
        SLOT_PULSE_ON  = 2'd1,
        SLOT_PULSE_OFF = 2'd2,
        SLOT_PULSE_END = 2'd3
    } slot_t;

    typedef struct packed {
        logic [TIME_W-1:0]    next_compare;
        logic                 status_one;
        logic                 status_two;
        logic [CHANNEL_W-1:0] adc_channel;
        logic                 adc_enable;
    } heartbeat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vhps_in_if  sample_ch ();
    vhps_out_if result_ch ();

    voltage_heartbeat_pulse_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // register copies and sequence state
    logic [TIME_W-1:0]    step_ticks;
    logic [GAIN_W-1:0]    gain;
    logic [OFFSET_W-1:0]  offset;
    logic [GAPS_W-1:0]    frame_gaps;
    slot_t                slot;
    logic [GAPS_W-1:0]    gaps_to_go;
    logic [TIME_W-1:0]    beat_time;
    logic [TIME_W-1:0]    edge_at;
    logic                 chan_sel;
    logic [CHANNEL_W-1:0] adc_ch;
    logic                 adc_on;

    logic [SAMPLE_W-1:0] pending_samples[$];
    heartbeat_t          due_heartbeats[$];

    logic in_beat;
    int   in_idle;
    int   out_idle;
    int   idle_odds;
    logic calm;
    int   quiet;
    int   errors;
    int   sent;

    function automatic heartbeat_t schedule_event(input logic [SAMPLE_W-1:0] s);
        heartbeat_t        h;
        logic [TIME_W-1:0] spacing;
        logic              lit;
        spacing = {12'd0, gain} * {6'd0, s} + {4'd0, offset};
        lit = 1'b0;
        case (slot)
            SLOT_GAP:
            begin
                beat_time = beat_time + step_ticks;
                h.next_compare = beat_time;
                gaps_to_go = gaps_to_go - 8'd1;
                if (gaps_to_go == 8'd0)
                begin
                    chan_sel = ~chan_sel;
                    adc_ch = ADC_CH_ONE;
                    adc_on = 1'b1;
                    slot = SLOT_PULSE_ON;
                end
            end
            SLOT_PULSE_ON:
            begin
                lit = 1'b1;
                edge_at = beat_time + spacing;
                h.next_compare = edge_at;
                adc_ch = ADC_CH_TWO;
                adc_on = 1'b1;
                slot = SLOT_PULSE_OFF;
            end
            SLOT_PULSE_OFF:
            begin
                edge_at = edge_at + spacing;
                h.next_compare = edge_at;
                adc_ch = ADC_CH_THREE;
                adc_on = 1'b1;
                slot = SLOT_PULSE_END;
            end
            default:
            begin
                lit = 1'b1;
                edge_at = edge_at + spacing;
                h.next_compare = edge_at;
                adc_on = 1'b0;
                gaps_to_go = frame_gaps;
                slot = SLOT_GAP;
            end
        endcase
        h.status_one = lit && chan_sel;
        h.status_two = lit && !chan_sel;
        h.adc_channel = adc_ch;
        h.adc_enable = adc_on;
        return h;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_GAP_STEP:       step_ticks = data;
            REG_PULSE_GAIN:     gain = data[GAIN_W-1:0];
            REG_PULSE_OFFSET:   offset = data[OFFSET_W-1:0];
            REG_GAPS_PER_FRAME: frame_gaps = data[GAPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every beat is through, then let the pipeline empty
    task automatic drain();
        while (pending_samples.size() != 0 || sample_ch.valid || due_heartbeats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return 10'd1023;
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic queue_samples(input int n);
        for (int i = 0; i < n; i++)
            pending_samples.push_back(pick_sample());
        sent += n;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || in_beat)
        begin
            if (in_idle > 0)
            begin
                in_idle--;
                sample_ch.valid <= 1'b0;
            end
            else if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            begin
                in_idle = $urandom_range(1, 9) - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_ch.valid <= 1'b1;
                sample_ch.adc_sample <= pending_samples.pop_front();
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (out_idle > 0)
        begin
            out_idle--;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
        begin
            out_idle = $urandom_range(1, 9) - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        heartbeat_t want;
        in_beat <= rst_n && sample_ch.valid && sample_ch.ready;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                due_heartbeats.push_back(schedule_event(sample_ch.adc_sample));
            if (result_ch.valid && result_ch.ready)
            begin
                if (due_heartbeats.size() == 0)
                    report_mismatch("result beat with nothing outstanding");
                else
                begin
                    want = due_heartbeats.pop_front();
                    if (result_ch.next_compare !== want.next_compare)
                        report_mismatch($sformatf("next_compare got %0d want %0d",
                            result_ch.next_compare, want.next_compare));
                    if (result_ch.status_one !== want.status_one)
                        report_mismatch($sformatf("status_one got %b want %b",
                            result_ch.status_one, want.status_one));
                    if (result_ch.status_two !== want.status_two)
                        report_mismatch($sformatf("status_two got %b want %b",
                            result_ch.status_two, want.status_two));
                    if (result_ch.adc_channel !== want.adc_channel)
                        report_mismatch($sformatf("adc_channel got %0d want %0d",
                            result_ch.adc_channel, want.adc_channel));
                    if (result_ch.adc_enable !== want.adc_enable)
                        report_mismatch($sformatf("adc_enable got %b want %b",
                            result_ch.adc_enable, want.adc_enable));
                end
            end
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("voltage_heartbeat_pulse_scheduler: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] v;
        int                    n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GAP_STEP;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready = 1'b0;
        in_beat = 1'b0;
        in_idle = 0;
        out_idle = 0;
        idle_odds = 4;
        calm = 1'b0;
        quiet = 0;
        errors = 0;
        sent = 0;
        step_ticks = GAP_STEP_RST;
        gain = PULSE_GAIN_RST;
        offset = PULSE_OFFSET_RST;
        frame_gaps = GAPS_PER_FRAME_RST;
        slot = SLOT_GAP;
        gaps_to_go = GAPS_PER_FRAME_RST;
        beat_time = '0;
        edge_at = '0;
        chan_sel = 1'b0;
        adc_ch = ADC_CH_ONE;
        adc_on = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one frame at reset settings, edge samples and alternating bits
        pending_samples = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd0,
                            10'd1023, 10'd0, 10'h2AA};
        drain();

        // widest spacing and step, one gap per frame, sums wrap
        write_reg(REG_GAP_STEP, 16'hFFFF);
        write_reg(REG_PULSE_GAIN, 16'h000F);
        write_reg(REG_PULSE_OFFSET, 16'h0FFF);
        write_reg(REG_GAPS_PER_FRAME, 16'h0001);
        end_writes();
        pending_samples = '{10'd1023, 10'd1023, 10'd1023, 10'd1023,
                            10'd1023, 10'd0, 10'd1023, 10'd1023};
        drain();

        // zero spacing and step, then change the frame length mid-frame
        write_reg(REG_GAP_STEP, 16'h0000);
        write_reg(REG_PULSE_GAIN, 16'h0000);
        write_reg(REG_PULSE_OFFSET, 16'h0000);
        end_writes();
        pending_samples = '{10'd1023, 10'd512};
        drain();
        write_reg(REG_GAPS_PER_FRAME, 16'h0003);
        end_writes();
        pending_samples = '{10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7};
        drain();

        // zero frame length: 256 gaps before the pulses
        write_reg(REG_GAP_STEP, 16'(12345));
        write_reg(REG_PULSE_GAIN, 16'h0007);
        write_reg(REG_PULSE_OFFSET, 16'h0800);
        write_reg(REG_GAPS_PER_FRAME, 16'hFF00);
        end_writes();
        queue_samples(3);
        drain();
        write_reg(REG_GAPS_PER_FRAME, 16'h0002);
        end_writes();
        queue_samples(262);
        drain();

        while (sent < 1400)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h0000;
                    1: v = 16'hFFFF;
                    default: v = 16'($urandom);
                endcase
                write_reg(REG_GAP_STEP, v);
            end
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_PULSE_GAIN, 16'($urandom));
            if ($urandom_range(0, 1) != 0)
            begin
                v = 16'($urandom);
                case ($urandom_range(0, 4))
                    0: v[OFFSET_W-1:0] = '0;
                    1: v[OFFSET_W-1:0] = '1;
                    default: ;
                endcase
                write_reg(REG_PULSE_OFFSET, v);
            end
            if ($urandom_range(0, 1) != 0)
            begin
                v = 16'($urandom);
                case ($urandom_range(0, 11))
                    0: v[GAPS_W-1:0] = 8'd0;
                    1: v[GAPS_W-1:0] = 8'd255;
                    default: v[GAPS_W-1:0] = GAPS_W'($urandom_range(1, 6));
                endcase
                write_reg(REG_GAPS_PER_FRAME, v);
            end
            end_writes();
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 2;
                default: idle_odds = 6;
            endcase
            n = $urandom_range(10, 120);
            queue_samples(n);
            drain();
        end

        calm = 1'b1;
        write_reg(REG_GAPS_PER_FRAME, 16'h0004);
        end_writes();
        queue_samples(100);
        drain();
        repeat (6) @(posedge clk);

        if (errors == 0)
            $display("voltage_heartbeat_pulse_scheduler: match");
        else
            $display("voltage_heartbeat_pulse_scheduler: mismatch");
        $finish;
    end

endmodule
